// ===== rtl/core/sem_pkg.sv =====
`default_nettype none
package sem_pkg;

  // Fixed field widths and frame limits
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int ROW_W      = 13;
  localparam int MAX_HEIGHT = 4096;
  localparam int PIX_W      = 8;
  localparam int GRAD_W     = 11;
  localparam int SUMSQ_W    = 21;
  localparam int ROOT_W     = 16;
  localparam int ROOT_STEPS = 8;

  // Sum of squares at or above this rounds to 255 or more
  localparam logic [SUMSQ_W-1:0] SAT_SUM = SUMSQ_W'(65281);
  localparam logic [PIX_W-1:0]   PIX_MAX = 8'hFF;

  // Configuration register index
  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } sem_reg_t;

  typedef struct packed {
    logic             action;
    logic [PIX_W-1:0] in_red;
    logic [PIX_W-1:0] in_green;
    logic [PIX_W-1:0] in_blue;
  } sem_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] edge_red;
    logic [PIX_W-1:0] edge_green;
    logic [PIX_W-1:0] edge_blue;
    logic             frame_end;
  } sem_out_t;

endpackage
`default_nettype wire

// ===== rtl/core/sobel_edge_magnitude_rgb.sv =====
// 3x3 Sobel edge magnitude on an RGB raster stream. Send pixels in raster
// order, then frame_width+1 padding items (action=1) after each frame; the
// result for a pixel comes out once its lower-right neighbor has been sent,
// and the last pixel's result carries frame_end. Pixels outside the frame
// count as zero. Per channel the result is round(sqrt(gx^2+gy^2)) clipped
// at 255. The two previous rows sit in two single-port line memories with a
// registered read. An item that yields a result goes, from transfer to the
// next possible transfer, through one memory read, one write-back and window
// shift, a gradient and a squaring stage, eight steps of the bit-pair square
// root and one output load; no new item is taken meanwhile. Items with no
// result (the first frame_width+1 of a frame) end after the window shift.
// A finished result waits in the output register while the next item is taken.
// Registers: frame_width at byte 0x0 (reset 640), frame_height at 0x4
// (reset 480); write them only while the block is idle.
`default_nettype none
module sobel_edge_magnitude_rgb
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire sem_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output sem_out_t         out_data,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WE_W  = $clog2(MAX_WIDTH + 1);
  localparam int TOT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 1);
  localparam int CR_W  = ROW_W + 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_GRAD,
    S_SQ,
    S_ROOT,
    S_OUT
  } state_t;

  state_t state_r;

  // Configuration
  logic [FW_W-1:0] frame_width_r;
  logic [FH_W-1:0] frame_height_r;
  logic            cfg_we;

  // Frame geometry
  logic [WE_W-1:0]      w_eff;
  logic [FH_W-1:0]      h_eff;
  logic [WE_W+FH_W-1:0] area;
  logic [TOT_W-1:0]     total_r;

  // Position counters
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [TOT_W-1:0] items_r;

  // Accept-time decode
  logic             in_xfer;
  logic [COL_W-1:0] col_cur;
  logic [WE_W-1:0]  col_inc;
  logic             col_last;
  logic [WE_W-1:0]  cc;
  logic signed [CR_W-1:0] cr;
  logic signed [CR_W-1:0] rr [3];
  logic [2:0]       rowok;
  logic [2:0]       colok;
  logic [8:0]       use_nxt;
  logic             has_res;
  logic             end_hit;

  // Item held through processing
  logic [COL_W-1:0] addr_r;
  logic [23:0]      pix_r;
  logic [8:0]       use_r;
  logic             has_res_r;
  logic             end_r;

  // Line memories
  logic [23:0] upper_mem [MAX_WIDTH];
  logic [23:0] middle_mem [MAX_WIDTH];
  logic [23:0] upper_q;
  logic [23:0] middle_q;
  logic        mem_we;

  // Window and arithmetic
  logic [23:0]               win_r [9];
  logic signed [GRAD_W-1:0]  gx_nxt [3];
  logic signed [GRAD_W-1:0]  gy_nxt [3];
  logic signed [GRAD_W-1:0]  gx_r [3];
  logic signed [GRAD_W-1:0]  gy_r [3];
  logic [SUMSQ_W-1:0]        sumsq [3];
  logic [2:0]                sat_r;
  logic [ROOT_W-1:0]         rx_r [3];
  logic [ROOT_W-1:0]         rq_r [3];
  logic [ROOT_W-1:0]         rx_nxt [3];
  logic [ROOT_W-1:0]         rq_nxt [3];
  logic [ROOT_W-1:0]         rbit_r;
  logic [$clog2(ROOT_STEPS)-1:0] step_r;
  logic [PIX_W-1:0]          edge_val [3];

  logic out_free;

  // Register port
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel & cfg_penable & cfg_pwrite;

  always_comb begin
    unique case (sem_reg_t'(cfg_paddr[2]))
      REG_WIDTH:  cfg_prdata = 32'(frame_width_r);
      REG_HEIGHT: cfg_prdata = 32'(frame_height_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // Clamp frame size into its legal range
  always_comb begin
    if (frame_width_r == '0) begin
      w_eff = WE_W'(1);
    end else if (32'(frame_width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WE_W'(MAX_WIDTH);
    end else begin
      w_eff = WE_W'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      h_eff = FH_W'(1);
    end else if (32'(frame_height_r) > 32'(MAX_HEIGHT)) begin
      h_eff = FH_W'(MAX_HEIGHT);
    end else begin
      h_eff = frame_height_r;
    end
  end

  assign area = (WE_W+FH_W)'(w_eff) * (WE_W+FH_W)'(h_eff);

  // Decode the position of the item at transfer
  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid & in_ready;

  always_comb begin
    col_cur  = (WE_W'(col_r) >= w_eff) ? '0 : col_r;
    col_inc  = WE_W'(col_cur) + WE_W'(1);
    col_last = (col_inc >= w_eff);
    if (col_cur != '0) begin
      cc = WE_W'(col_cur) - WE_W'(1);
      cr = signed'(CR_W'(row_r)) - CR_W'(1);
    end else begin
      cc = w_eff - WE_W'(1);
      cr = signed'(CR_W'(row_r)) - CR_W'(2);
    end
    for (int k = 0; k < 3; k++) begin
      rr[k]    = cr + signed'(CR_W'(k)) - signed'(CR_W'(1));
      rowok[k] = !rr[k][CR_W-1] && (rr[k] < signed'(CR_W'(h_eff)));
    end
    colok[0] = (cc != '0);
    colok[1] = 1'b1;
    colok[2] = ((cc + WE_W'(1)) < w_eff);
    for (int k = 0; k < 9; k++) begin
      use_nxt[k] = rowok[k / 3] & colok[k % 3];
    end
    has_res = (items_r >= (TOT_W'(w_eff) + TOT_W'(1)));
    end_hit = (items_r >= total_r);
  end

  // Line memories: read at transfer, write back in the following cycle
  assign mem_we = (state_r == S_RD);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      upper_mem[addr_r] <= middle_q;
    end
    if (in_xfer) begin
      upper_q <= upper_mem[col_cur];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      middle_mem[addr_r] <= pix_r;
    end
    if (in_xfer) begin
      middle_q <= middle_mem[col_cur];
    end
  end

  // Sobel gradients per channel
  always_comb begin
    logic signed [GRAD_W-1:0] p [9];
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 9; k++) begin
        p[k] = use_r[k] ? signed'(GRAD_W'(win_r[k][16 - 8 * ch +: 8])) : '0;
      end
      gx_nxt[ch] = (p[2] + (p[5] <<< 1) + p[8]) - (p[0] + (p[3] <<< 1) + p[6]);
      gy_nxt[ch] = (p[6] + (p[7] <<< 1) + p[8]) - (p[0] + (p[1] <<< 1) + p[2]);
    end
  end

  // Sum of squares
  always_comb begin
    logic signed [2*GRAD_W-1:0] sx;
    logic signed [2*GRAD_W-1:0] sy;
    logic [2*GRAD_W-1:0]        ss;
    for (int ch = 0; ch < 3; ch++) begin
      sx        = gx_r[ch] * gx_r[ch];
      sy        = gy_r[ch] * gy_r[ch];
      ss        = unsigned'(sx) + unsigned'(sy);
      sumsq[ch] = ss[SUMSQ_W-1:0];
    end
  end

  // One bit-pair step of the square root
  always_comb begin
    logic [ROOT_W:0] trial;
    for (int ch = 0; ch < 3; ch++) begin
      trial = (ROOT_W+1)'(rq_r[ch]) + (ROOT_W+1)'(rbit_r);
      if ((ROOT_W+1)'(rx_r[ch]) >= trial) begin
        rx_nxt[ch] = rx_r[ch] - trial[ROOT_W-1:0];
        rq_nxt[ch] = (rq_r[ch] >> 1) + rbit_r;
      end else begin
        rx_nxt[ch] = rx_r[ch];
        rq_nxt[ch] = rq_r[ch] >> 1;
      end
    end
  end

  // Round up when the remainder exceeds the root, then clip
  always_comb begin
    logic [ROOT_W:0] rnd;
    for (int ch = 0; ch < 3; ch++) begin
      rnd = (ROOT_W+1)'(rq_r[ch]) + ((rx_r[ch] > rq_r[ch]) ? (ROOT_W+1)'(1) : '0);
      if (sat_r[ch] || (rnd > (ROOT_W+1)'(PIX_MAX))) begin
        edge_val[ch] = PIX_MAX;
      end else begin
        edge_val[ch] = rnd[PIX_W-1:0];
      end
    end
  end

  assign out_free = !out_valid || out_ready;

  // Sequencer, counters, window and output register
  always_ff @(posedge clk) begin
    total_r <= TOT_W'(area) + TOT_W'(w_eff);
    if (!rst_n) begin
      state_r        <= S_IDLE;
      frame_width_r  <= FW_W'(640);
      frame_height_r <= FH_W'(480);
      col_r          <= '0;
      row_r          <= '0;
      items_r        <= '0;
      out_valid      <= 1'b0;
      for (int k = 0; k < 9; k++) begin
        win_r[k] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (sem_reg_t'(cfg_paddr[2]))
          REG_WIDTH:  frame_width_r  <= cfg_pwdata[FW_W-1:0];
          REG_HEIGHT: frame_height_r <= cfg_pwdata[FH_W-1:0];
          default:    ;
        endcase
      end

      // Raise valid on a result load, drop it once the result is taken
      if (state_r == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            addr_r    <= col_cur;
            pix_r     <= in_data.action ? '0
                         : {in_data.in_red, in_data.in_green, in_data.in_blue};
            use_r     <= use_nxt;
            has_res_r <= has_res;
            end_r     <= end_hit;
            if (has_res && end_hit) begin
              col_r   <= '0;
              row_r   <= '0;
              items_r <= '0;
            end else begin
              items_r <= items_r + TOT_W'(1);
              if (col_last) begin
                col_r <= '0;
                row_r <= row_r + ROW_W'(1);
              end else begin
                col_r <= col_inc[COL_W-1:0];
              end
            end
            state_r <= S_RD;
          end
        end
        S_RD: begin
          // Shift the window left by one column
          for (int k = 0; k < 3; k++) begin
            win_r[k * 3 + 0] <= win_r[k * 3 + 1];
            win_r[k * 3 + 1] <= win_r[k * 3 + 2];
          end
          win_r[2] <= upper_q;
          win_r[5] <= middle_q;
          win_r[8] <= pix_r;
          state_r  <= has_res_r ? S_GRAD : S_IDLE;
        end
        S_GRAD: begin
          for (int ch = 0; ch < 3; ch++) begin
            gx_r[ch] <= gx_nxt[ch];
            gy_r[ch] <= gy_nxt[ch];
          end
          state_r <= S_SQ;
        end
        S_SQ: begin
          for (int ch = 0; ch < 3; ch++) begin
            sat_r[ch] <= (sumsq[ch] >= SAT_SUM);
            rx_r[ch]  <= sumsq[ch][ROOT_W-1:0];
            rq_r[ch]  <= '0;
          end
          rbit_r  <= ROOT_W'(1) << (ROOT_W - 2);
          step_r  <= '0;
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          for (int ch = 0; ch < 3; ch++) begin
            rx_r[ch] <= rx_nxt[ch];
            rq_r[ch] <= rq_nxt[ch];
          end
          rbit_r <= rbit_r >> 2;
          step_r <= step_r + ($clog2(ROOT_STEPS))'(1);
          if (step_r == ($clog2(ROOT_STEPS))'(ROOT_STEPS - 1)) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          // Load the result once the output register is free
          if (out_free) begin
            out_data.edge_red   <= edge_val[0];
            out_data.edge_green <= edge_val[1];
            out_data.edge_blue  <= edge_val[2];
            out_data.frame_end  <= end_r;
            state_r             <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // A transfer always starts the memory read cycle
  assert property (@(posedge clk) disable iff (!rst_n) in_xfer |=> state_r == S_RD)
    else $error("transfer not followed by line memory read");

  // A new result appears only from the output load state
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_OUT))
    else $error("result loaded outside output state");

  // Frame end restarts the position counters
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && has_res && end_hit) |=> (items_r == '0 && col_r == '0 && row_r == '0))
    else $error("counters not cleared at frame end");

  // The root never exceeds eight bits when the output is loaded
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> (rq_r[0] <= ROOT_W'(PIX_MAX) && rq_r[1] <= ROOT_W'(PIX_MAX)
                            && rq_r[2] <= ROOT_W'(PIX_MAX)))
    else $error("square root out of range");

endmodule
`default_nettype wire
